FILE: sv/shm_pkg.sv
// shared types and constants for the string key hash map
// used by shm_mod_unit, shm_store and string_key_hash_map
package shm_pkg;

	localparam int TABLE_SLOTS_D  = 64;
	localparam int STRING_BYTES_D = 32;
	localparam int HASH_W         = 64;
	localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
	localparam int MOD_STEPS      = 4;   // remainder bits per cycle

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4,
		ST_EMPTY     = 3'd5,
		ST_TOO_LONG  = 3'd6
	} status_t;

	typedef struct packed {
		logic wr;       // byte store write
		logic meta_wr;  // length store write
	} store_ctl_t;

endpackage

FILE: sv/string_key_hash_map.sv
// string key hash map top level: request collection, probe sequencer, results
// depends on shm_pkg, shm_mod_unit, shm_store
//
// A request is a run of words taken while start is high and busy low: key
// bytes (part 0), then value bytes for an insert (part 1), the last one
// with last high; zero bytes carry no character. After the last word the
// block holds busy high while it reduces the hash to a slot: it launches
// the remainder unit, waits on it and then decides on refusals. It then
// walks slots from there: it tests occupancy, reads the stored lengths and
// compares the key byte by byte, since the next byte is fetched from the
// byte store while the current one is compared. An insert then writes every
// byte of the longer of key and value. A find streams its value one byte a
// cycle. Results appear for exactly one cycle with done high; the receiver
// cannot stall them. The tables start empty after reset, no clearing pass.
// The request lengths return to zero with the closing result word.
module string_key_hash_map #(
	parameter int TABLE_SLOTS  = shm_pkg::TABLE_SLOTS_D,
	parameter int STRING_BYTES = shm_pkg::STRING_BYTES_D
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            kind,
	input  logic                            part,
	input  logic [7:0]                      char_byte,
	input  logic                            last,
	output logic                            done,
	output logic [2:0]                      status,
	output logic [$clog2(TABLE_SLOTS)-1:0]  slot,
	output logic [7:0]                      value_byte,
	output logic                            last_res
);
	import shm_pkg::*;

	localparam int IW   = $clog2(TABLE_SLOTS);
	localparam int BW   = $clog2(STRING_BYTES);
	localparam int LW   = $clog2(STRING_BYTES + 1);
	localparam int CW   = $clog2(TABLE_SLOTS + 1);
	localparam int AW   = $clog2(TABLE_SLOTS * STRING_BYTES);
	localparam int KEEP = STRING_BYTES - 1;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_MODGO   = 9'b000000010,
		S_MODWAIT = 9'b000000100,
		S_DECIDE  = 9'b000001000,
		S_PROBE   = 9'b000010000,
		S_META    = 9'b000100000,
		S_CMP     = 9'b001000000,
		S_WRITE   = 9'b010000000,
		S_STREAM  = 9'b100000000
	} state_t;

	state_t state_q;

	// request being collected
	logic [7:0]        req_key_q [KEEP];
	logic [7:0]        req_val_q [KEEP];
	logic [LW-1:0]     rklen_q;
	logic [LW-1:0]     rvlen_q;
	logic [HASH_W-1:0] hash_q;
	logic              kind_q;

	// table bookkeeping
	logic [TABLE_SLOTS-1:0] occ_q;
	logic [CW-1:0]          count_q;

	// probe walk
	logic [IW-1:0] start_q;
	logic [IW-1:0] cur_q;
	logic [BW-1:0] idx_q;
	logic [BW-1:0] vlen_q;
	logic          hit_q;

	// result word
	logic          done_q;
	status_t       status_q;
	logic [IW-1:0] slot_q;
	logic [7:0]    vbyte_q;
	logic          lastr_q;

	logic          mod_go;
	logic          mod_done;
	logic [IW-1:0] mod_rem;

	store_ctl_t         st_ctl;
	logic [AW-1:0]      base;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic [15:0]        wr_data;
	logic [15:0]        rd_data;
	logic [2*BW-1:0]    meta_wr_data;
	logic [2*BW-1:0]    meta_rd;
	logic [BW-1:0]      rd_idx;

	logic          accept;
	logic [IW-1:0] nxt_slot;
	logic          key_eq;
	logic          key_end;
	logic          val_end;
	logic          wr_end;
	logic [LW-1:0] wlen;
	logic [LW-1:0] idx_inc;
	logic [BW-1:0] meta_kl;
	logic [BW-1:0] meta_vl;

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);
	assign idx_inc = LW'(idx_q) + LW'(1);
	assign meta_kl = meta_rd[2*BW-1:BW];
	assign meta_vl = meta_rd[BW-1:0];
	assign key_eq  = (rd_data[15:8] == req_key_q[idx_q]);
	assign key_end = (idx_inc == rklen_q);
	assign val_end = (idx_inc == LW'(vlen_q));
	assign wlen    = (rklen_q > rvlen_q) ? rklen_q : rvlen_q;
	assign wr_end  = (idx_inc == wlen);
	assign nxt_slot = (cur_q == IW'(TABLE_SLOTS - 1)) ? '0 : cur_q + 1'b1;

	// byte store addressing: slot base plus byte offset
	assign base = AW'(cur_q) * AW'(STRING_BYTES);

	always_comb begin
		rd_idx = '0;
		case (state_q)
			S_CMP:    rd_idx = (key_eq && !key_end) ? idx_q + 1'b1 : '0;
			S_STREAM: rd_idx = idx_q + 1'b1;
			default:  rd_idx = '0;
		endcase
	end

	assign rd_addr      = base + AW'(rd_idx);
	assign wr_addr      = base + AW'(idx_q);
	assign wr_data      = {req_key_q[idx_q], req_val_q[idx_q]};
	assign meta_wr_data = {rklen_q[BW-1:0], rvlen_q[BW-1:0]};
	assign st_ctl.wr      = (state_q == S_WRITE);
	assign st_ctl.meta_wr = (state_q == S_WRITE) && wr_end;
	assign mod_go         = (state_q == S_MODGO);

	shm_mod_unit #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (mod_go),
		.value (hash_q),
		.done  (mod_done),
		.rem   (mod_rem)
	);

	shm_store #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.STRING_BYTES(STRING_BYTES)
	) u_store (
		.clk         (clk),
		.ctl         (st_ctl),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_data     (rd_data),
		.meta_addr   (cur_q),
		.meta_wr_data(meta_wr_data),
		.meta_rd_data(meta_rd)
	);

	// request buffers, no reset needed
	always_ff @(posedge clk) begin
		if (accept && char_byte != 8'd0) begin
			if (!part && rklen_q < LW'(KEEP)) begin
				req_key_q[rklen_q[BW-1:0]] <= char_byte;
			end
			if (part && rvlen_q < LW'(KEEP)) begin
				req_val_q[rvlen_q[BW-1:0]] <= char_byte;
			end
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rklen_q  <= '0;
			rvlen_q  <= '0;
			hash_q   <= HASH_SEED;
			kind_q   <= 1'b0;
			occ_q    <= '0;
			count_q  <= '0;
			start_q  <= '0;
			cur_q    <= '0;
			idx_q    <= '0;
			vlen_q   <= '0;
			hit_q    <= 1'b0;
			done_q   <= 1'b0;
			status_q <= ST_NOT_FOUND;
			slot_q   <= '0;
			vbyte_q  <= '0;
			lastr_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (char_byte != 8'd0) begin
							if (!part) begin
								if (rklen_q < LW'(KEEP)) begin
									hash_q <= ((hash_q << 5) + hash_q) ^ HASH_W'(char_byte);
								end
								if (rklen_q < LW'(STRING_BYTES)) begin
									rklen_q <= rklen_q + 1'b1;
								end
							end else if (rvlen_q < LW'(STRING_BYTES)) begin
								rvlen_q <= rvlen_q + 1'b1;
							end
						end
						if (last) begin
							kind_q  <= kind;
							state_q <= S_MODGO;
						end
					end
				end
				S_MODGO: begin
					// the remainder unit has taken the hash, ready for the next key
					hash_q  <= HASH_SEED;
					state_q <= S_MODWAIT;
				end
				S_MODWAIT: begin
					if (mod_done) begin
						start_q <= mod_rem;
						cur_q   <= mod_rem;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					// refusals and unusable find keys end the request here
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					slot_q  <= '0;
					vbyte_q <= '0;
					lastr_q <= 1'b1;
					if (!kind_q) begin
						if (rklen_q == '0 || rklen_q >= LW'(STRING_BYTES)) begin
							status_q <= ST_NOT_FOUND;
							rklen_q  <= '0;
							rvlen_q  <= '0;
						end else begin
							done_q  <= 1'b0;
							state_q <= S_PROBE;
						end
					end else if (count_q >= CW'(TABLE_SLOTS)) begin
						status_q <= ST_FULL;
						rklen_q  <= '0;
						rvlen_q  <= '0;
					end else if (rklen_q == '0 || rvlen_q == '0) begin
						status_q <= ST_EMPTY;
						rklen_q  <= '0;
						rvlen_q  <= '0;
					end else if (rklen_q >= LW'(STRING_BYTES) ||
					             rvlen_q >= LW'(STRING_BYTES)) begin
						status_q <= ST_TOO_LONG;
						rklen_q  <= '0;
						rvlen_q  <= '0;
					end else begin
						done_q  <= 1'b0;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (occ_q[cur_q]) begin
						state_q <= S_META;
					end else if (kind_q) begin
						hit_q   <= 1'b0;
						idx_q   <= '0;
						state_q <= S_WRITE;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_NOT_FOUND;
						slot_q   <= '0;
						vbyte_q  <= '0;
						lastr_q  <= 1'b1;
						rklen_q  <= '0;
						rvlen_q  <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_META: begin
					vlen_q <= meta_vl;
					idx_q  <= '0;
					if (LW'(meta_kl) == rklen_q) begin
						state_q <= S_CMP;
					end else if (nxt_slot == start_q) begin
						// a whole turn without a match
						done_q   <= 1'b1;
						status_q <= ST_NOT_FOUND;
						slot_q   <= '0;
						vbyte_q  <= '0;
						lastr_q  <= 1'b1;
						rklen_q  <= '0;
						rvlen_q  <= '0;
						state_q  <= S_IDLE;
					end else begin
						cur_q   <= nxt_slot;
						state_q <= S_PROBE;
					end
				end
				S_CMP: begin
					if (!key_eq) begin
						if (nxt_slot == start_q) begin
							done_q   <= 1'b1;
							status_q <= ST_NOT_FOUND;
							slot_q   <= '0;
							vbyte_q  <= '0;
							lastr_q  <= 1'b1;
							rklen_q  <= '0;
							rvlen_q  <= '0;
							state_q  <= S_IDLE;
						end else begin
							cur_q   <= nxt_slot;
							state_q <= S_PROBE;
						end
					end else if (key_end) begin
						hit_q   <= 1'b1;
						idx_q   <= '0;
						state_q <= kind_q ? S_WRITE : S_STREAM;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_WRITE: begin
					idx_q <= idx_q + 1'b1;
					if (wr_end) begin
						occ_q[cur_q] <= 1'b1;
						if (!hit_q) begin
							count_q <= count_q + 1'b1;
						end
						done_q   <= 1'b1;
						status_q <= hit_q ? ST_UPDATED : ST_INSERTED;
						slot_q   <= cur_q;
						vbyte_q  <= '0;
						lastr_q  <= 1'b1;
						rklen_q  <= '0;
						rvlen_q  <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_STREAM: begin
					done_q   <= 1'b1;
					status_q <= ST_FOUND;
					slot_q   <= cur_q;
					vbyte_q  <= rd_data[7:0];
					lastr_q  <= val_end;
					idx_q    <= idx_q + 1'b1;
					if (val_end) begin
						rklen_q <= '0;
						rvlen_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign slot       = slot_q;
	assign value_byte = vbyte_q;
	assign last_res   = lastr_q;

	// a result that ends a request leaves the block ready for the next one
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q && lastr_q |-> !busy)
		else $error("request ended while still busy");

	// only a found value is spread over several words
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !lastr_q |-> status_q == ST_FOUND)
		else $error("unfinished result word that is not a found byte");

	// the table never holds more entries than slots
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_SLOTS))
		else $error("entry count beyond table size");

	// the closing word of a request always starts the lookup
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> busy && !done_q)
		else $error("closing word did not start the lookup");

endmodule

FILE: sv/shm_mod_unit.sv
// iterative remainder of the 64-bit hash by the slot count
// depends on shm_pkg
module shm_mod_unit #(
	parameter int TABLE_SLOTS = shm_pkg::TABLE_SLOTS_D
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             go,
	input  logic [shm_pkg::HASH_W-1:0]       value,
	output logic                             done,
	output logic [$clog2(TABLE_SLOTS)-1:0]   rem
);
	import shm_pkg::*;

	localparam int IW   = $clog2(TABLE_SLOTS);
	localparam int RW   = IW + 1;
	localparam int NCYC = HASH_W / MOD_STEPS;
	localparam int CW   = $clog2(NCYC);

	logic              run_q;
	logic [CW-1:0]     cnt_q;
	logic [HASH_W-1:0] val_q;
	logic [RW-1:0]     acc_q;
	logic [RW-1:0]     acc_n;

	// restoring remainder, a few bits a cycle
	always_comb begin
		acc_n = acc_q;
		for (int k = 0; k < MOD_STEPS; k++) begin
			acc_n = {acc_n[RW-2:0], val_q[HASH_W-1-k]};
			if (acc_n >= RW'(TABLE_SLOTS)) begin
				acc_n = acc_n - RW'(TABLE_SLOTS);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NCYC - 1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			val_q <= value;
			acc_q <= '0;
		end else if (run_q) begin
			val_q <= val_q << MOD_STEPS;
			acc_q <= acc_n;
		end
	end

	assign rem = acc_q[IW-1:0];

endmodule

FILE: sv/shm_store.sv
// byte store (key and value byte pairs) and per-slot length store
// depends on shm_pkg; both memories have registered reads
module shm_store #(
	parameter int TABLE_SLOTS  = shm_pkg::TABLE_SLOTS_D,
	parameter int STRING_BYTES = shm_pkg::STRING_BYTES_D
) (
	input  logic                                             clk,
	input  shm_pkg::store_ctl_t                              ctl,
	input  logic [$clog2(TABLE_SLOTS*STRING_BYTES)-1:0]      rd_addr,
	input  logic [$clog2(TABLE_SLOTS*STRING_BYTES)-1:0]      wr_addr,
	input  logic [15:0]                                      wr_data,
	output logic [15:0]                                      rd_data,
	input  logic [$clog2(TABLE_SLOTS)-1:0]                   meta_addr,
	input  logic [2*$clog2(STRING_BYTES)-1:0]                meta_wr_data,
	output logic [2*$clog2(STRING_BYTES)-1:0]                meta_rd_data
);
	import shm_pkg::*;

	localparam int DEPTH = TABLE_SLOTS * STRING_BYTES;
	localparam int MW    = 2 * $clog2(STRING_BYTES);

	logic [15:0]   bytes_mem [DEPTH];
	logic [MW-1:0] meta_mem  [TABLE_SLOTS];

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			bytes_mem[wr_addr] <= wr_data;
		end
		rd_data <= bytes_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.meta_wr) begin
			meta_mem[meta_addr] <= meta_wr_data;
		end
		meta_rd_data <= meta_mem[meta_addr];
	end

endmodule

FILE: verif/string_key_hash_map_checker.sv
// checker for string_key_hash_map: watches the request and result channels
// keeps its own copy of the table, predicts each result word and compares
// depends on shm_pkg for the status codes and the hash seed
module string_key_hash_map_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic       kind,
	input  logic       part,
	input  logic [7:0] char_byte,
	input  logic       last,
	input  logic       done,
	input  logic [2:0] status,
	input  logic [5:0] slot,
	input  logic [7:0] value_byte,
	input  logic       last_res,
	output int         errors,
	output int         pending,
	output int         words_in,
	output int         words_out
);
	import shm_pkg::*;

	localparam int SLOTS = 64;
	localparam int MAXB  = 32;
	localparam int KEEP  = MAXB - 1;

	typedef struct {
		status_t    st;
		logic [5:0] sl;
		logic [7:0] vb;
		logic       lr;
	} map_result_t;

	map_result_t expected_results[$];

	logic [7:0]  key_mem [SLOTS][KEEP];
	logic [7:0]  val_mem [SLOTS][KEEP];
	int          key_len [SLOTS];
	int          val_len [SLOTS];
	bit          occ [SLOTS];
	int          entries;
	logic [7:0]  req_key [KEEP];
	logic [7:0]  req_val [KEEP];
	int          req_klen, req_vlen;
	logic [63:0] hash;

	assign pending = expected_results.size();

	task automatic report(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	function automatic bit key_equal(int s);
		if (!occ[s] || key_len[s] != req_klen) return 0;
		for (int i = 0; i < req_klen; i++)
			if (key_mem[s][i] != req_key[i]) return 0;
		return 1;
	endfunction

	// linear probe from the hashed slot, one turn at most
	function automatic int probe_slot(output bit hit);
		int first, s;
		first = int'(hash[5:0]);
		s = first;
		hit = 0;
		while (occ[s]) begin
			if (key_equal(s)) begin
				hit = 1;
				return s;
			end
			s = (s + 1) % SLOTS;
			if (s == first) break;
		end
		return s;
	endfunction

	function automatic void push_result(status_t st, int sl, logic [7:0] vb, bit lr);
		map_result_t r;
		r.st = st; r.sl = sl[5:0]; r.vb = vb; r.lr = lr;
		expected_results.push_back(r);
	endfunction

	function automatic void clear_request();
		req_klen = 0;
		req_vlen = 0;
		hash = HASH_SEED;
	endfunction

	function automatic void take_word(logic k, logic p, logic [7:0] c, logic l);
		bit hit;
		int s;
		if (c != 0) begin
			if (!p) begin
				if (req_klen < KEEP) begin
					req_key[req_klen] = c;
					hash = (hash * 33) ^ {56'd0, c};
				end
				if (req_klen < MAXB) req_klen++;
			end else begin
				if (req_vlen < KEEP) req_val[req_vlen] = c;
				if (req_vlen < MAXB) req_vlen++;
			end
		end
		if (!l) return;
		if (!k) begin
			hit = 0;
			if (req_klen != 0 && req_klen < MAXB) s = probe_slot(hit);
			if (hit && val_len[s] > 0) begin
				for (int i = 0; i < val_len[s]; i++)
					push_result(ST_FOUND, s, val_mem[s][i], i + 1 == val_len[s]);
			end else
				push_result(ST_NOT_FOUND, 0, 8'd0, 1);
		end else if (entries >= SLOTS)
			push_result(ST_FULL, 0, 8'd0, 1);
		else if (req_klen == 0 || req_vlen == 0)
			push_result(ST_EMPTY, 0, 8'd0, 1);
		else if (req_klen >= MAXB || req_vlen >= MAXB)
			push_result(ST_TOO_LONG, 0, 8'd0, 1);
		else begin
			s = probe_slot(hit);
			for (int i = 0; i < req_vlen; i++) val_mem[s][i] = req_val[i];
			val_len[s] = req_vlen;
			if (hit)
				push_result(ST_UPDATED, s, 8'd0, 1);
			else begin
				for (int i = 0; i < req_klen; i++) key_mem[s][i] = req_key[i];
				key_len[s] = req_klen;
				occ[s] = 1;
				entries++;
				push_result(ST_INSERTED, s, 8'd0, 1);
			end
		end
		clear_request();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		map_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) occ[i] = 0;
			entries = 0;
			clear_request();
		end else begin
			if (done) begin
				words_out++;
				if (expected_results.size() == 0) begin
					$display("mismatch at %0t: result word with none expected", $realtime);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (status !== e.st) report("status", status, e.st);
					if (slot !== e.sl) report("slot", slot, e.sl);
					if (value_byte !== e.vb) report("value_byte", value_byte, e.vb);
					if (last_res !== e.lr) report("last_res", last_res, e.lr);
				end
			end
			if (start && !busy) begin
				words_in++;
				take_word(kind, part, char_byte, last);
			end
		end
	end

	initial begin
		errors = 0;
		words_in = 0;
		words_out = 0;
	end

endmodule

FILE: verif/tb_string_key_hash_map.sv
// testbench top for string_key_hash_map: clock, reset, request stimulus, verdict
// depends on shm_pkg, string_key_hash_map and string_key_hash_map_checker
module tb_string_key_hash_map;
	typedef logic [7:0] text_t[$];

	logic       clk = 0;
	logic       arst_n = 0;
	logic       start = 0;
	logic       kind = 0;
	logic       part = 0;
	logic [7:0] char_byte = 0;
	logic       last = 0;
	logic       busy, done, last_res;
	logic [2:0] status;
	logic [5:0] slot;
	logic [7:0] value_byte;
	int         errors, pending, words_in, words_out;
	int         requests = 0;

	always #5 clk = ~clk;

	string_key_hash_map dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .part(part), .char_byte(char_byte), .last(last),
		.done(done), .status(status), .slot(slot), .value_byte(value_byte),
		.last_res(last_res)
	);

	string_key_hash_map_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .part(part), .char_byte(char_byte), .last(last),
		.done(done), .status(status), .slot(slot), .value_byte(value_byte),
		.last_res(last_res), .errors(errors), .pending(pending),
		.words_in(words_in), .words_out(words_out)
	);

	// idle length before a word: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// one word, held until the block takes it; start stays high into the next word
	task automatic send_word(logic k, logic p, logic [7:0] c, logic l);
		int g;
		g = pick_gap();
		if (g > 0) begin
			start <= 0;
			repeat (g) @(posedge clk);
		end
		start <= 1;
		kind <= k;
		part <= p;
		char_byte <= c;
		last <= l;
		do @(posedge clk); while (busy);
	endtask

	// key words then value words, last on the final one; an empty request
	// still needs one word, so a zero byte carries the last flag
	task automatic send_request(logic k, text_t key_txt, text_t val_txt);
		int n;
		n = key_txt.size() + val_txt.size();
		requests++;
		if (n == 0) begin
			send_word(k, 1'($urandom_range(1)), 8'd0, 1);
			return;
		end
		foreach (key_txt[i]) send_word(k, 0, key_txt[i], n == i + 1);
		foreach (val_txt[i]) send_word(k, 1, val_txt[i], n == key_txt.size() + i + 1);
	endtask

	// random string; a small alphabet when narrow is set so that updates and hits happen,
	// with the odd zero byte that must be skipped
	function automatic text_t rand_text(int len, bit narrow);
		text_t t;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(15) == 0) t.push_back(8'd0);
			if (narrow) t.push_back(8'($urandom_range(6, 1)) | 8'($urandom_range(1) << 7));
			else t.push_back(8'($urandom_range(255, 1)));
		end
		return t;
	endfunction

	function automatic int rand_len();
		int r;
		r = $urandom_range(99);
		if (r < 85) return $urandom_range(3, 1);
		if (r < 92) return $urandom_range(30, 4);
		if (r < 96) return 31;
		return $urandom_range(34, 32);
	endfunction

	initial begin
		text_t no_text, k, v;
		int r;
		no_text = {};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: miss on an empty table, new insert, hit, update, hit with
		// stray value words, empty key, empty value, empty find, byte extremes
		send_request(0, '{8'h61}, no_text);
		send_request(1, '{8'h61}, '{8'hff});
		send_request(0, '{8'h61}, no_text);
		send_request(1, '{8'h61}, '{8'h78, 8'h00, 8'h79, 8'h7a});
		send_request(0, '{8'h61}, '{8'h01, 8'h80});
		send_request(1, no_text, '{8'h76});
		send_request(1, '{8'h6b, 8'h00}, '{8'h00});
		send_request(0, no_text, no_text);
		send_request(1, '{8'hff, 8'h01}, '{8'h80});
		send_request(0, '{8'hff, 8'h01}, no_text);
		send_request(0, '{8'h01, 8'hff}, no_text);

		// random: mostly well formed inserts and finds, some noise requests
		for (int n = 0; n < 3; n++) begin
			r = $urandom_range(99);
			if (r < 85) begin
				k = rand_text(rand_len(), 1'($urandom_range(1)));
				v = rand_text(rand_len(), 0);
				if (r < 50) send_request(1, k, v);
				else send_request(0, k, (r < 80) ? no_text : v);
			end else begin
				int len;
				logic kk;
				len = $urandom_range(4, 1);
				kk = 1'($urandom_range(1));
				requests++;
				for (int i = 0; i < len; i++)
					send_word(kk, 1'($urandom_range(1)), 8'($urandom_range(255)),
						i == len - 1);
			end
		end

		// fill the table with one byte keys, then hit the full refusal, an update
		// refused on a full table, a find that hits and a find that walks a whole turn
		for (int b = 7; b <= 70; b++) send_request(1, '{8'(b)}, rand_text(1, 0));
		send_request(1, '{8'h07}, '{8'h55});
		send_request(1, no_text, no_text);
		send_request(0, '{8'h07}, no_text);
		send_request(0, '{8'h90, 8'h91}, no_text);
		start <= 0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d requests sent as %0d words, %0d result words checked",
			requests, words_in, words_out);
		$display("covered misses, hits, updates, empty strings and a full table");
		if (errors == 0 && pending == 0)
			$display("string_key_hash_map test passed");
		else
			$display("string_key_hash_map test failed");
		$finish;
	end

	initial begin
		#40000000;
		$display("string_key_hash_map test failed");
		$finish;
	end

endmodule
